>>> hw/rtl/bst_preorder_to_postorder_core_defines.svh
// Assertion macros shared by the preorder to postorder converter.
// Depends on nothing. Each user declares aclk and aresetn in its own scope.
`ifndef BST_PREORDER_TO_POSTORDER_CORE_DEFINES_SVH
`define BST_PREORDER_TO_POSTORDER_CORE_DEFINES_SVH

// Clocked property check, switched off while reset is held.
`define BST_P2P_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Check that a condition never occurs.
`define BST_P2P_ASSERT_NEVER(lbl, expr, msg) \
    `BST_P2P_ASSERT(lbl, !(expr), msg)

`endif

>>> hw/rtl/bst_p2p_pkg.sv
// Package for the preorder to postorder converter: sizes, item types,
// stack entry layout and sequencer state codes. Depends on nothing.
package bst_p2p_pkg;

    // Capacity in keys; also the depth of the key store and of the range stack.
    localparam int MAX_KEYS = 64;
    localparam int IDX_W    = $clog2(MAX_KEYS);
    localparam int CNT_W    = $clog2(MAX_KEYS + 1);
    localparam int KEY_W    = 32;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             is_last;
    } in_item_t;

    typedef struct packed {
        logic [KEY_W-1:0] key_out;
        logic             last_out;
        logic             overflow;
    } out_item_t;

    // One pending range on the stack; done marks a range that only emits its root.
    typedef struct packed {
        logic             done;
        logic [IDX_W-1:0] hi;
        logic [IDX_W-1:0] lo;
    } stack_entry_t;

    localparam int STACK_W = $bits(stack_entry_t);

    // Result handed from the sequencer to the output register.
    typedef struct packed {
        logic      valid;
        out_item_t item;
    } emit_t;

    typedef enum logic [7:0] {
        ST_LOAD       = 8'b0000_0001,
        ST_ROOT       = 8'b0000_0010,
        ST_SCAN       = 8'b0000_0100,
        ST_PUSH_DONE  = 8'b0000_1000,
        ST_PUSH_RIGHT = 8'b0001_0000,
        ST_POP        = 8'b0010_0000,
        ST_POP_WAIT   = 8'b0100_0000,
        ST_EMIT       = 8'b1000_0000
    } seq_state_t;

endpackage

>>> hw/rtl/bst_p2p_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; read data holds while no read is issued.
module bst_p2p_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/bst_p2p_outreg.sv
// Output register for the converter's result channel.
// Depends on bst_p2p_pkg; decouples the sequencer from a stalling receiver.
module bst_p2p_outreg (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  bst_p2p_pkg::emit_t    emit,
    output logic                  out_free,
    output logic                  m_valid,
    input  logic                  m_ready,
    output bst_p2p_pkg::out_item_t m_item
);
    import bst_p2p_pkg::*;

    logic      m_valid_reg;
    logic      m_valid_next;
    out_item_t m_item_reg;

    // The register can take a new item when empty or when its item leaves now.
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_free) begin
            m_valid_next = emit.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge aclk) begin
        if (out_free && emit.valid) begin
            m_item_reg <= emit.item;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

>>> hw/rtl/bst_p2p_seq.sv
// Sequencer of the converter: loads keys, scans ranges for their split point,
// drives the range stack and emits roots. Depends on bst_p2p_pkg and the
// assertion macros in bst_preorder_to_postorder_core_defines.svh.
`include "bst_preorder_to_postorder_core_defines.svh"
module bst_p2p_seq (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  bst_p2p_pkg::in_item_t                 s_item,
    // Key store port.
    output logic                                  key_wr_en,
    output logic [bst_p2p_pkg::IDX_W-1:0]         key_wr_addr,
    output logic [bst_p2p_pkg::KEY_W-1:0]         key_wr_data,
    output logic                                  key_rd_en,
    output logic [bst_p2p_pkg::IDX_W-1:0]         key_rd_addr,
    input  logic [bst_p2p_pkg::KEY_W-1:0]         key_rd_data,
    // Range stack port.
    output logic                                  stk_wr_en,
    output logic [bst_p2p_pkg::IDX_W-1:0]         stk_wr_addr,
    output bst_p2p_pkg::stack_entry_t             stk_wr_data,
    output logic                                  stk_rd_en,
    output logic [bst_p2p_pkg::IDX_W-1:0]         stk_rd_addr,
    input  bst_p2p_pkg::stack_entry_t             stk_rd_data,
    // Result towards the output register.
    output bst_p2p_pkg::emit_t                    emit,
    input  logic                                  out_free
);
    import bst_p2p_pkg::*;

    seq_state_t       state_reg,     state_next;
    logic [CNT_W-1:0] key_count_reg, key_count_next;
    logic [CNT_W-1:0] sp_reg,        sp_next;
    logic             dropped_reg,   dropped_next;
    logic [IDX_W-1:0] cur_lo_reg,    cur_lo_next;
    logic [IDX_W-1:0] cur_hi_reg,    cur_hi_next;
    logic             cur_done_reg,  cur_done_next;
    logic [IDX_W-1:0] chk_idx_reg,   chk_idx_next;
    logic [KEY_W-1:0] root_key_reg,  root_key_next;
    logic [IDX_W-1:0] split_reg,     split_next;
    logic [IDX_W-1:0] left_hi_reg,   left_hi_next;
    logic             has_right_reg, has_right_next;
    logic             has_left_reg,  has_left_next;

    logic [CNT_W-1:0] count_dec;
    logic [CNT_W-1:0] sp_dec;
    logic             has_room;
    logic             stack_room;

    assign count_dec  = key_count_reg - CNT_W'(1);
    assign sp_dec     = sp_reg - CNT_W'(1);
    assign has_room   = key_count_reg < CNT_W'(MAX_KEYS);
    assign stack_room = sp_reg < CNT_W'(MAX_KEYS);

    // Next-state logic; the left part of a range is taken up at once rather
    // than pushed, so only the root entry and the right part use the stack.
    always_comb begin
        state_next     = state_reg;
        key_count_next = key_count_reg;
        sp_next        = sp_reg;
        dropped_next   = dropped_reg;
        cur_lo_next    = cur_lo_reg;
        cur_hi_next    = cur_hi_reg;
        cur_done_next  = cur_done_reg;
        chk_idx_next   = chk_idx_reg;
        root_key_next  = root_key_reg;
        split_next     = split_reg;
        left_hi_next   = left_hi_reg;
        has_right_next = has_right_reg;
        has_left_next  = has_left_reg;

        s_ready     = 1'b0;
        key_wr_en   = 1'b0;
        key_wr_addr = key_count_reg[IDX_W-1:0];
        key_wr_data = s_item.key;
        key_rd_en   = 1'b0;
        key_rd_addr = cur_lo_reg;
        stk_wr_en   = 1'b0;
        stk_wr_addr = sp_reg[IDX_W-1:0];
        stk_wr_data = '{done: 1'b1, hi: cur_lo_reg, lo: cur_lo_reg};
        stk_rd_en   = 1'b0;
        stk_rd_addr = sp_dec[IDX_W-1:0];
        emit.valid         = 1'b0;
        emit.item.key_out  = key_rd_data;
        emit.item.last_out = (sp_reg == '0);
        emit.item.overflow = dropped_reg;

        case (state_reg)
            ST_LOAD: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (has_room) begin
                        key_wr_en      = 1'b1;
                        key_count_next = key_count_reg + CNT_W'(1);
                    end else begin
                        dropped_next = 1'b1;
                    end
                    if (s_item.is_last) begin
                        cur_lo_next   = '0;
                        cur_done_next = 1'b0;
                        cur_hi_next   = has_room ? key_count_reg[IDX_W-1:0]
                                                 : count_dec[IDX_W-1:0];
                        state_next    = ST_ROOT;
                    end
                end
            end
            ST_ROOT: begin
                key_rd_en    = 1'b1;
                chk_idx_next = cur_lo_reg;
                if (cur_done_reg || (cur_lo_reg == cur_hi_reg)) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // One key a cycle: read the next index while checking the last.
                if (chk_idx_reg != cur_hi_reg) begin
                    key_rd_en    = 1'b1;
                    key_rd_addr  = chk_idx_reg + IDX_W'(1);
                    chk_idx_next = chk_idx_reg + IDX_W'(1);
                end
                if (chk_idx_reg == cur_lo_reg) begin
                    root_key_next = key_rd_data;
                end else if (key_rd_data > root_key_reg) begin
                    split_next     = chk_idx_reg;
                    has_right_next = 1'b1;
                    has_left_next  = (chk_idx_reg != (cur_lo_reg + IDX_W'(1)));
                    left_hi_next   = chk_idx_reg - IDX_W'(1);
                    state_next     = ST_PUSH_DONE;
                end else if (chk_idx_reg == cur_hi_reg) begin
                    has_right_next = 1'b0;
                    has_left_next  = 1'b1;
                    left_hi_next   = cur_hi_reg;
                    state_next     = ST_PUSH_DONE;
                end
            end
            ST_PUSH_DONE: begin
                if (stack_room) begin
                    stk_wr_en = 1'b1;
                    sp_next   = sp_reg + CNT_W'(1);
                end
                if (has_right_reg) begin
                    state_next = ST_PUSH_RIGHT;
                end else if (has_left_reg) begin
                    cur_lo_next = cur_lo_reg + IDX_W'(1);
                    cur_hi_next = left_hi_reg;
                    state_next  = ST_ROOT;
                end else begin
                    state_next = ST_POP;
                end
            end
            ST_PUSH_RIGHT: begin
                stk_wr_data = '{done: 1'b0, hi: cur_hi_reg, lo: split_reg};
                if (stack_room) begin
                    stk_wr_en = 1'b1;
                    sp_next   = sp_reg + CNT_W'(1);
                end
                if (has_left_reg) begin
                    cur_lo_next = cur_lo_reg + IDX_W'(1);
                    cur_hi_next = left_hi_reg;
                    state_next  = ST_ROOT;
                end else begin
                    state_next = ST_POP;
                end
            end
            ST_POP: begin
                stk_rd_en  = 1'b1;
                sp_next    = sp_dec;
                state_next = ST_POP_WAIT;
            end
            ST_POP_WAIT: begin
                cur_lo_next   = stk_rd_data.lo;
                cur_hi_next   = stk_rd_data.hi;
                cur_done_next = stk_rd_data.done;
                state_next    = ST_ROOT;
            end
            ST_EMIT: begin
                // The key read data holds until the output register is free.
                if (out_free) begin
                    emit.valid = 1'b1;
                    if (sp_reg == '0) begin
                        key_count_next = '0;
                        dropped_next   = 1'b0;
                        state_next     = ST_LOAD;
                    end else begin
                        state_next = ST_POP;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            key_count_reg <= '0;
            sp_reg        <= '0;
            dropped_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            key_count_reg <= key_count_next;
            sp_reg        <= sp_next;
            dropped_reg   <= dropped_next;
        end
    end

    // Range and scan registers need no reset.
    always_ff @(posedge aclk) begin
        cur_lo_reg    <= cur_lo_next;
        cur_hi_reg    <= cur_hi_next;
        cur_done_reg  <= cur_done_next;
        chk_idx_reg   <= chk_idx_next;
        root_key_reg  <= root_key_next;
        split_reg     <= split_next;
        left_hi_reg   <= left_hi_next;
        has_right_reg <= has_right_next;
        has_left_reg  <= has_left_next;
    end

    // The stack and the key count never pass the capacity.
    `BST_P2P_ASSERT(a_sp_bound, (sp_reg <= CNT_W'(MAX_KEYS)), "range stack overrun")
    `BST_P2P_ASSERT(a_count_bound, (key_count_reg <= CNT_W'(MAX_KEYS)), "key count overrun")
    // A pop is only issued with entries on the stack.
    `BST_P2P_ASSERT_NEVER(a_pop_empty, ((state_reg == ST_POP) && (sp_reg == '0)), "pop on empty stack")
    // The scan stays within the current range.
    `BST_P2P_ASSERT(a_scan_range, (state_reg == ST_SCAN) |-> ((chk_idx_reg >= cur_lo_reg) && (chk_idx_reg <= cur_hi_reg)), "scan index outside range")
    // After the final result the block is empty and loading again.
    `BST_P2P_ASSERT(a_run_end, (emit.valid && emit.item.last_out) |=> ((state_reg == ST_LOAD) && (key_count_reg == '0) && !dropped_reg), "run did not end cleanly")

endmodule

>>> hw/rtl/bst_preorder_to_postorder_core.sv
// Top level of the binary search tree preorder to postorder converter.
// Depends on bst_p2p_pkg, bst_p2p_ram, bst_p2p_seq and bst_p2p_outreg.
//
// Usage:
//   Keys enter on the s_ channel in preorder, one item per cycle while the
//   block is loading; the item with is_last set closes the sequence. Up to
//   MAX_KEYS keys are stored; later keys are dropped and every result of that
//   run carries overflow. After the last key the block stops taking items,
//   rebuilds the tree order from the key store with a range stack and sends
//   the keys in postorder on the m_ channel, last_out on the final one.
//   In the output phase every range with more than one key is scanned up
//   to its split point, and its root and right part go on the range stack.
//   The split scan reads the key store one key per cycle on its single read
//   port, so a degenerate tree gives the longest scans.
//   A stalled receiver holds the single output register and the sequencer
//   waits; nothing is lost. The next sequence may start loading while the
//   final result still waits in the output register.
//   Reset (aresetn low, synchronous) empties the block: no keys are stored,
//   the overflow mark is clear and no result is pending.
module bst_preorder_to_postorder_core (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  bst_p2p_pkg::in_item_t  s_item,
    output logic                   m_valid,
    input  logic                   m_ready,
    output bst_p2p_pkg::out_item_t m_item
);
    import bst_p2p_pkg::*;

    logic               key_wr_en;
    logic [IDX_W-1:0]   key_wr_addr;
    logic [KEY_W-1:0]   key_wr_data;
    logic               key_rd_en;
    logic [IDX_W-1:0]   key_rd_addr;
    logic [KEY_W-1:0]   key_rd_data;
    logic               stk_wr_en;
    logic [IDX_W-1:0]   stk_wr_addr;
    stack_entry_t       stk_wr_data;
    logic               stk_rd_en;
    logic [IDX_W-1:0]   stk_rd_addr;
    logic [STACK_W-1:0] stk_rd_raw;
    stack_entry_t       stk_rd_data;
    emit_t              emit;
    logic               out_free;

    assign stk_rd_data = stack_entry_t'(stk_rd_raw);

    // Key store.
    bst_p2p_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_KEYS)
    ) u_key_ram (
        .aclk    (aclk),
        .wr_en   (key_wr_en),
        .wr_addr (key_wr_addr),
        .wr_data (key_wr_data),
        .rd_en   (key_rd_en),
        .rd_addr (key_rd_addr),
        .rd_data (key_rd_data)
    );

    // Range stack.
    bst_p2p_ram #(
        .WIDTH (STACK_W),
        .DEPTH (MAX_KEYS)
    ) u_stack_ram (
        .aclk    (aclk),
        .wr_en   (stk_wr_en),
        .wr_addr (stk_wr_addr),
        .wr_data (STACK_W'(stk_wr_data)),
        .rd_en   (stk_rd_en),
        .rd_addr (stk_rd_addr),
        .rd_data (stk_rd_raw)
    );

    // Sequencer.
    bst_p2p_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .key_wr_en   (key_wr_en),
        .key_wr_addr (key_wr_addr),
        .key_wr_data (key_wr_data),
        .key_rd_en   (key_rd_en),
        .key_rd_addr (key_rd_addr),
        .key_rd_data (key_rd_data),
        .stk_wr_en   (stk_wr_en),
        .stk_wr_addr (stk_wr_addr),
        .stk_wr_data (stk_wr_data),
        .stk_rd_en   (stk_rd_en),
        .stk_rd_addr (stk_rd_addr),
        .stk_rd_data (stk_rd_data),
        .emit        (emit),
        .out_free    (out_free)
    );

    // Output register.
    bst_p2p_outreg u_outreg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .emit     (emit),
        .out_free (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

endmodule

>>> bench/bst_p2p_tb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard class for the preorder to postorder converter testbench.
// Depends on bst_p2p_pkg for the item types and the capacity.
package bst_p2p_tb_pkg;

    import bst_p2p_pkg::*;

    // A range of stored keys still to be handled; root_only marks one that only emits its root.
    typedef struct {
        int lo;
        int hi;
        bit root_only;
    } key_span_t;

    class postorder_tracker;

        logic [KEY_W-1:0] loaded_keys[$];
        bit               keys_dropped;
        out_item_t        pending_results[$];
        int unsigned      errors;

        function new();
            keys_dropped = 1'b0;
            errors       = 0;
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        // Store an accepted key; the item that closes a sequence releases its postorder.
        function void take_key(in_item_t item);
            if (loaded_keys.size() < MAX_KEYS) begin
                loaded_keys.insert(loaded_keys.size(), item.key);
            end else begin
                keys_dropped = 1'b1;
            end
            if (item.is_last) begin
                queue_postorder();
                loaded_keys.delete();
                keys_dropped = 1'b0;
            end
        endfunction

        // Walk the stored keys with a work list: left part, right part, then the root.
        // Each range splits at the first key strictly above its root, so equal keys go left.
        function void queue_postorder();
            key_span_t work[$];
            key_span_t cur;
            key_span_t nxt;
            out_item_t res;
            int        split;
            cur.lo        = 0;
            cur.hi        = loaded_keys.size() - 1;
            cur.root_only = 1'b0;
            work.insert(work.size(), cur);
            while (work.size() > 0) begin
                cur = work.pop_back();
                if (cur.root_only) begin
                    res.key_out  = loaded_keys[cur.lo];
                    res.last_out = 1'b0;
                    res.overflow = keys_dropped;
                    pending_results.insert(pending_results.size(), res);
                end else begin
                    split = cur.hi + 1;
                    for (int i = cur.lo + 1; i <= cur.hi; i++) begin
                        if (loaded_keys[i] > loaded_keys[cur.lo]) begin
                            split = i;
                            break;
                        end
                    end
                    nxt.lo        = cur.lo;
                    nxt.hi        = cur.lo;
                    nxt.root_only = 1'b1;
                    work.insert(work.size(), nxt);
                    if (split <= cur.hi) begin
                        nxt.lo        = split;
                        nxt.hi        = cur.hi;
                        nxt.root_only = 1'b0;
                        work.insert(work.size(), nxt);
                    end
                    if (split >= cur.lo + 2) begin
                        nxt.lo        = cur.lo + 1;
                        nxt.hi        = split - 1;
                        nxt.root_only = 1'b0;
                        work.insert(work.size(), nxt);
                    end
                end
            end
            // The final key of the run carries the end marker.
            res = pending_results.pop_back();
            res.last_out = 1'b1;
            pending_results.insert(pending_results.size(), res);
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        // Compare an accepted result with the oldest expected one.
        task check_result(out_item_t got);
            out_item_t want;
            if (pending_results.size() == 0) begin
                report($sformatf("result with no expected item, key_out %h", got.key_out));
                return;
            end
            want = pending_results.pop_front();
            if (got.key_out !== want.key_out)
                report($sformatf("key_out %h, expected %h", got.key_out, want.key_out));
            if (got.last_out !== want.last_out)
                report($sformatf("last_out %b, expected %b (key %h)",
                                 got.last_out, want.last_out, want.key_out));
            if (got.overflow !== want.overflow)
                report($sformatf("overflow %b, expected %b (key %h)",
                                 got.overflow, want.overflow, want.key_out));
        endtask

    endclass

endpackage

>>> bench/tb_bst_preorder_to_postorder_core.sv
`timescale 1ns / 1ps
// Testbench for bst_preorder_to_postorder_core: drives preorder key sequences with random
// gaps and stalls and checks every postorder result. Depends on bst_p2p_pkg and bst_p2p_tb_pkg.
module tb_bst_preorder_to_postorder_core;

    import bst_p2p_pkg::*;
    import bst_p2p_tb_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;

    postorder_tracker tracker;
    logic [KEY_W-1:0] run_keys[$];
    bit               tx_quiet;
    bit               left_chain;
    int               results_seen;
    int               idle_cycles;

    bst_preorder_to_postorder_core u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always #5 aclk = ~aclk;

    // Mostly no gap or a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Append a well-formed preorder subtree of count keys drawn from [lo, hi] to run_keys.
    // Keys equal to a root go to its left, keys above it to its right.
    function automatic void grow_subtree(logic [KEY_W-1:0] lo, logic [KEY_W-1:0] hi,
                                         int count);
        logic [KEY_W-1:0] root;
        int               n_left;
        int               r;
        if (count == 0) return;
        r = $urandom_range(0, 3);
        if (lo == hi || left_chain || r == 0) begin
            n_left = count - 1;
        end else if (r == 1) begin
            n_left = 0;
        end else begin
            n_left = $urandom_range(0, count - 1);
        end
        if (n_left < count - 1) begin
            root = $urandom_range(hi - 1, lo);
        end else begin
            root = $urandom_range(hi, lo);
        end
        run_keys.insert(run_keys.size(), root);
        grow_subtree(lo, root, n_left);
        grow_subtree(root + 1, hi, count - 1 - n_left);
    endfunction

    // Offer one item and hold it until it is accepted.
    task automatic send_key(input logic [KEY_W-1:0] key, input logic last);
        in_item_t item;
        item.key     = key;
        item.is_last = last;
        s_valid <= 1'b1;
        s_item  <= item;
        do @(posedge aclk); while (!s_ready);
        tracker.take_key(item);
    endtask

    // Send run_keys as one sequence, the last one flagged, with random gaps between items.
    task automatic send_run();
        int gap;
        for (int i = 0; i < run_keys.size(); i++) begin
            send_key(run_keys[i], i == run_keys.size() - 1);
            gap = tx_quiet ? 0 : pick_gap();
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // Result monitor.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            tracker.check_result(m_item);
            results_seen++;
        end
    end

    // Watchdog on cycles in which no item moves on either side.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("[%0t] no item moved for %0d cycles", $time, STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    // Receiver: random stalls, quiet stretches, and one long hold-off while results pile up.
    initial begin
        int stall_left;
        bit rx_quiet;
        bit held;
        stall_left = 0;
        rx_quiet   = 1'b0;
        held       = 1'b0;
        m_ready <= 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if ($urandom_range(0, 255) == 0) rx_quiet = !rx_quiet;
            if (!held && results_seen >= 40) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                stall_left = rx_quiet ? 0 : pick_gap();
            end
        end
    end

    // Reset, directed sequences, random sequences, then drain.
    initial begin
        int random_items;
        int run_no;
        int r;
        tracker      = new();
        results_seen = 0;
        idle_cycles  = 0;
        tx_quiet     = 1'b0;
        left_chain   = 1'b0;
        random_items = 0;
        run_no       = 0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_item  <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Single keys at both extremes of the key range.
        run_keys = '{32'h0000_0000};
        send_run();
        run_keys = '{32'hFFFF_FFFF};
        send_run();
        // Largest root with the smallest left child, then the other way round.
        run_keys = '{32'hFFFF_FFFF, 32'h0000_0000};
        send_run();
        run_keys = '{32'h0000_0000, 32'hFFFF_FFFF};
        send_run();
        // Equal keys all fall into the left subtree.
        run_keys = '{32'd7, 32'd7, 32'd7};
        send_run();
        // A balanced tree.
        run_keys = '{32'd8, 32'd3, 32'd1, 32'd5, 32'd12, 32'd10, 32'd14};
        send_run();
        // A sequence that is not a valid preorder is still split by the same rule.
        run_keys = '{32'd5, 32'd9, 32'd2, 32'd7};
        send_run();

        while (random_items < 140) begin
            run_keys.delete();
            tx_quiet   = ($urandom_range(0, 3) == 0);
            left_chain = 1'b0;
            r = $urandom_range(0, 99);
            if (run_no == 0) begin
                // Full capacity as a degenerate chain: the longest split scans.
                left_chain = 1'b1;
                grow_subtree(32'h0, 32'hFFFF_FFFF, MAX_KEYS);
            end else if (run_no == 1) begin
                // Full store, then a few more keys, the last among them, that are all dropped.
                grow_subtree(32'h0, $urandom_range(63, 0), MAX_KEYS);
                repeat ($urandom_range(1, 6)) run_keys.insert(run_keys.size(), $urandom);
            end else if (r < 45) begin
                grow_subtree(32'h0, 32'hFFFF_FFFF, $urandom_range(1, 10));
            end else if (r < 70) begin
                // Narrow key range, so duplicates are common.
                grow_subtree(32'h0, $urandom_range(40, 0), $urandom_range(1, 12));
            end else if (r < 85) begin
                repeat ($urandom_range(1, 8)) run_keys.insert(run_keys.size(), $urandom);
            end else begin
                repeat ($urandom_range(1, 8))
                    run_keys.insert(run_keys.size(), $urandom_range(0, 7));
            end
            random_items += run_keys.size();
            send_run();
            run_no++;
        end
        s_valid <= 1'b0;

        while (tracker.outstanding() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (tracker.errors == 0 && tracker.outstanding() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/bst_p2p_pkg.sv
hw/rtl/bst_p2p_ram.sv
hw/rtl/bst_p2p_outreg.sv
hw/rtl/bst_p2p_seq.sv
hw/rtl/bst_preorder_to_postorder_core.sv
bench/bst_p2p_tb_pkg.sv
bench/tb_bst_preorder_to_postorder_core.sv
